// File: design/ktd_pkg.sv
// Shared types, codes and entry update functions for the key tap/hold/double detector.
// No dependencies; used by ktd_store and key_tap_hold_double_detector.
`default_nettype none

package ktd_pkg;

  // Table depth default
  localparam int KTD_NUM_KEYS = 256;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 8;
  localparam int DT_W     = 10;
  localparam int PHASE_W  = 3;
  localparam int TIMER_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_DOWN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_RELEASED = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PRESSED  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_HELD     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_COOLDOWN = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DOUBLE   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DBL_THR = 1'b1;

  localparam logic [TIMER_W-1:0] TAP_THR_RESET = 16'd200;
  localparam logic [TIMER_W-1:0] DBL_THR_RESET = 16'd300;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key_code;
    logic [DT_W-1:0]  elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] key_state;
    logic               is_held;
    logic               is_pressed;
    logic               is_double_pressed;
  } out_item_t;

  // One table entry
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TIMER_W-1:0] timer;
  } entry_t;

  // Saturating timer advance
  function automatic logic [TIMER_W-1:0] add_sat(logic [TIMER_W-1:0] t,
                                                 logic [DT_W-1:0] dt);
    logic [TIMER_W:0] s;
    s = {1'b0, t} + (TIMER_W+1)'(dt);
    return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
  endfunction

  // Entry after one tick
  function automatic entry_t tick_entry(entry_t e, logic [DT_W-1:0] dt,
                                        logic [TIMER_W-1:0] tap_thr,
                                        logic [TIMER_W-1:0] dbl_thr);
    entry_t n;
    logic [TIMER_W-1:0] t;
    n = e;
    t = add_sat(e.timer, dt);
    case (e.phase)
      PH_PRESSED: begin
        n.timer = t;
        if (t >= tap_thr) n.phase = PH_HELD;
      end
      PH_HELD: begin
        n.timer = t;
      end
      PH_COOLDOWN: begin
        if (t >= dbl_thr) begin
          n.phase = PH_RELEASED;
          n.timer = '0;
        end else begin
          n.timer = t;
        end
      end
      default: n = e;
    endcase
    return n;
  endfunction

  // Entry after a key down or key up
  function automatic entry_t key_entry(entry_t e, logic [CMD_W-1:0] cmd);
    entry_t n;
    n = e;
    if (cmd == CMD_DOWN) begin
      if (e.phase == PH_RELEASED) begin
        n.phase = PH_PRESSED;
      end else if (e.phase == PH_COOLDOWN) begin
        n.phase = PH_DOUBLE;
        n.timer = '0;
      end
    end else if (cmd == CMD_UP) begin
      n.phase = (e.phase == PH_PRESSED) ? PH_COOLDOWN : PH_RELEASED;
      n.timer = '0;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: design/ktd_store.sv
// Key entry table: one write port, one read port with registered read data.
// Depends on ktd_pkg for the entry type.
`default_nettype none

module ktd_store #(
  parameter int NUM_KEYS = ktd_pkg::KTD_NUM_KEYS,
  parameter int ADDR_W   = $clog2(NUM_KEYS)
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [ADDR_W-1:0]      wr_addr,
  input  wire ktd_pkg::entry_t        wr_entry,
  input  wire logic [ADDR_W-1:0]      rd_addr,
  output ktd_pkg::entry_t             rd_entry
);
  import ktd_pkg::*;

  entry_t mem [NUM_KEYS];
  entry_t rd_entry_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_entry;
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_entry_r <= mem[rd_addr];
  end

  assign rd_entry = rd_entry_r;

endmodule

`default_nettype wire

// File: design/key_tap_hold_double_detector.sv
// Per-key tap / hold / double-tap classifier over a table of key entries.
// Depends on ktd_pkg and ktd_store.
`default_nettype none

// After reset the block clears its table, one entry a cycle, with busy
// high. A key down, key up or query is accepted when start is high and busy
// low; busy then stays high through a table read state and an update and
// write back state, and the result strobes on the following cycle; a new
// command is taken only once busy is low again. A tick walks every entry
// through the table's read and write ports, one entry a cycle with read and
// write back overlapped, then reads and reports the addressed key, with busy
// high throughout. Every command gives exactly one result, shown for one
// cycle under out_strobe; it cannot be held off. Configuration writes land at
// once and are meant to happen while no command is in flight.
module key_tap_hold_double_detector #(
  parameter int NUM_KEYS = ktd_pkg::KTD_NUM_KEYS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire ktd_pkg::in_item_t               in_item,
  // result channel
  output logic                                 out_strobe,
  output ktd_pkg::out_item_t                   out_item,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [ktd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ktd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ktd_pkg::*;

  localparam int ADDR_W = $clog2(NUM_KEYS);
  localparam int CNT_W  = $clog2(NUM_KEYS + 1);

  // Sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SWP  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              swp_vld_r, swp_vld_nxt;
  in_item_t          item_r, item_nxt;
  logic [TIMER_W-1:0] tap_thr_r, dbl_thr_r;
  logic              out_strobe_r, out_strobe_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  entry_t            mem_rdata;

  logic              key_ok;
  logic [ADDR_W-1:0] key_addr;
  entry_t            key_new;
  logic [PHASE_W-1:0] res_phase;

  ktd_store #(
    .NUM_KEYS (NUM_KEYS),
    .ADDR_W   (ADDR_W)
  ) u_store (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  (mem_waddr),
    .wr_entry (mem_wdata),
    .rd_addr  (mem_raddr),
    .rd_entry (mem_rdata)
  );

  assign key_ok   = 32'(item_r.key_code) < 32'(NUM_KEYS);
  assign key_addr = ADDR_W'(item_r.key_code);
  assign key_new  = key_entry(mem_rdata, item_r.cmd);
  // tick and query report the entry as read; down and up report the update
  assign res_phase = !key_ok ? PH_RELEASED :
                     ((item_r.cmd == CMD_DOWN) || (item_r.cmd == CMD_UP)) ?
                     key_new.phase : mem_rdata.phase;

  // Sequencer and table access
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    swp_vld_nxt    = 1'b0;
    item_nxt       = item_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;
    mem_waddr      = key_addr;
    mem_wdata      = key_new;
    mem_raddr      = key_addr;
    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[ADDR_W-1:0];
        mem_wdata = '0;
        if (cnt_r == CNT_W'(NUM_KEYS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          cnt_nxt   = '0;
          state_nxt = (in_item.cmd == CMD_TICK) ? S_SWP : S_RD;
        end
      end
      S_SWP: begin
        // read entry cnt while writing back the one read last cycle
        mem_raddr = cnt_r[ADDR_W-1:0];
        mem_waddr = rd_idx_r;
        mem_wdata = tick_entry(mem_rdata, item_r.elapsed_ms, tap_thr_r, dbl_thr_r);
        mem_we    = swp_vld_r;
        if (cnt_r != CNT_W'(NUM_KEYS)) begin
          rd_idx_nxt  = cnt_r[ADDR_W-1:0];
          swp_vld_nxt = 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        mem_we  = key_ok && ((item_r.cmd == CMD_DOWN) || (item_r.cmd == CMD_UP));
        out_strobe_nxt                 = 1'b1;
        out_item_nxt.key_state         = res_phase;
        out_item_nxt.is_held           = (res_phase == PH_HELD);
        out_item_nxt.is_pressed        = (res_phase == PH_PRESSED);
        out_item_nxt.is_double_pressed = (res_phase == PH_DOUBLE);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      cnt_r        <= '0;
      swp_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
      tap_thr_r    <= TAP_THR_RESET;
      dbl_thr_r    <= DBL_THR_RESET;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      swp_vld_r    <= swp_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we && (cfg_index == REG_TAP_THR)) tap_thr_r <= cfg_wdata;
      if (cfg_we && (cfg_index == REG_DBL_THR)) dbl_thr_r <= cfg_wdata;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe lasted more than one cycle");

  a_strobe_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_nxt |-> (state_r == S_WB))
    else $error("result produced outside write-back");

  a_sweep_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWP && swp_vld_r && cnt_r != CNT_W'(NUM_KEYS)) |->
    (rd_idx_r != cnt_r[ADDR_W-1:0]))
    else $error("sweep read and write hit the same entry");

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $onehot0({out_item.is_held, out_item.is_pressed,
                             out_item.is_double_pressed}))
    else $error("more than one phase flag set");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (busy && !out_strobe_nxt))
    else $error("activity during table clear");

endmodule

`default_nettype wire
